/* hdl/sba_pkg.sv */
// ----------------------------------------------------------------------------
// sba_pkg
// Shared constants and codes for the slot bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

   localparam int SLOTS_DEFAULT = 4096;

   // Field widths.
   localparam int CMD_W    = 3;
   localparam int POS_W    = 41;
   localparam int TYPE_W   = 16;
   localparam int BLOB_W   = 64;
   localparam int STAT_W   = 2;
   localparam int FOUND_W  = 32;
   localparam int CNT_W    = 13;
   localparam int OSIZE_W  = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Product of a slot index and the object size.
   localparam int PROD_W = CNT_W + OSIZE_W;

   // Bitmap word.
   localparam int WORD_W   = 32;
   localparam int WORD_SEL = 5;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_FIND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TEST  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_USED  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INVALID   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWNER_TYPE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWNER_BLOB  = 2'd3;

endpackage

/* hdl/slot_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_core
// Next-fit slot allocator over a used-bit map held in a word-wide memory.
// ----------------------------------------------------------------------------
// The map is kept as 32-bit words in one memory, and one small sequencer
// drives a single read port, a single write port, one multiplier and one
// compare-and-subtract unit. After reset the block sweeps the map clear, one
// word per cycle, and accepts no transaction meanwhile. Test, mark used and
// mark free run one multiply for the bound, 13 divide steps to turn the byte
// position into a slot, then a read of one map word and, for mark used and
// mark free, a write-back of it. A find reads and then evaluates each map
// word it visits. A clear sweeps every map word clear. A new transaction is
// taken only when the sequencer is idle; the result register lets it finish
// while the last result waits.
module slot_bitmap_allocator_core #(
   parameter int SLOTS = sba_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sba_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sba_pkg::CMD_W-1:0]     req_command,
   input  logic signed [sba_pkg::POS_W-1:0] req_position,
   input  logic [sba_pkg::TYPE_W-1:0]    req_type_code,
   input  logic [sba_pkg::BLOB_W-1:0]    req_blob_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sba_pkg::STAT_W-1:0]    rsp_status,
   output logic [sba_pkg::FOUND_W-1:0]   rsp_found_position,
   output logic [sba_pkg::CNT_W-1:0]     rsp_slots_used
);
   import sba_pkg::*;

   localparam int ROWS    = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W   = ROW_W + WORD_SEL;
   localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int LIM_CAP = (SLOTS < 8191) ? SLOTS : 8191;
   localparam int STEP_W  = $clog2(CNT_W + 1);

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_CMP   = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_DCHK  = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_EVAL  = 4'd7;
   localparam logic [3:0] ST_FMUL  = 4'd8;
   localparam logic [3:0] ST_FOUT  = 4'd9;
   localparam logic [3:0] ST_CLEAR = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   // Configuration.
   logic [OSIZE_W-1:0] object_size_ff;
   logic [CNT_W-1:0]   slot_limit_ff;
   logic [TYPE_W-1:0]  owner_type_ff;
   logic [BLOB_W-1:0]  owner_blob_ff;

   // Sequencer and datapath.
   logic [3:0]         state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               addr_ok_ff, addr_ok_in;
   logic [CNT_W-1:0]   used_cnt_ff, used_cnt_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               phase_ff, phase_in;
   logic [PROD_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [FOUND_W-1:0] found_ff, found_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0] rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   // Map memory.
   logic [WORD_W-1:0]  map_mem [ROWS];
   logic [WORD_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [WORD_W-1:0]  mem_wdata;

   logic [CNT_W-1:0]   lim;
   logic [CNT_W-1:0]   mul_a;
   logic [ROW_W-1:0]   uc_row;
   logic [ROW_W-1:0]   last_row;
   logic [WORD_W-1:0]  free_bits;
   logic               any_free;
   logic [WORD_SEL-1:0] free_sel;
   logic               cur_bit;
   logic               accept;
   logic               out_free;

   assign lim = (slot_limit_ff > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : slot_limit_ff;
   assign uc_row   = ROW_W'(used_cnt_ff >> WORD_SEL);
   assign last_row = ROW_W'((lim - CNT_W'(1)) >> WORD_SEL);
   assign cur_bit  = rd_data_ff[slot_ff[WORD_SEL-1:0]];
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_slots_used     = rsp_cnt_ff;

   // Shared multiplier: the position bound, or the byte offset of a found slot.
   assign mul_a   = (state_ff == ST_FMUL) ? slot_ff : lim;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(object_size_ff);

   // Free slots of the current word that lie inside the search window.
   always_comb begin
      logic [CMP_W-1:0] idx;
      logic [CMP_W-1:0] uc_w;
      logic [CMP_W-1:0] lim_w;
      uc_w      = CMP_W'(used_cnt_ff);
      lim_w     = CMP_W'(lim);
      free_bits = '0;
      for (int j = 0; j < WORD_W; j++) begin
         idx = CMP_W'({row_ff, WORD_SEL'(j)});
         if (!phase_ff) begin
            free_bits[j] = !rd_data_ff[j] && (idx >= uc_w) && (idx < lim_w);
         end else begin
            free_bits[j] = !rd_data_ff[j] && (idx < uc_w);
         end
      end
   end

   always_comb begin
      any_free = 1'b0;
      free_sel = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            any_free = 1'b1;
            free_sel = WORD_SEL'(j);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      pos_in      = pos_ff;
      addr_ok_in  = addr_ok_ff;
      used_cnt_in = used_cnt_ff;
      slot_in     = slot_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      step_in     = step_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      mem_we      = 1'b0;
      mem_wdata   = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we = 1'b1;
            row_in = row_ff + ROW_W'(1);
            if (row_ff == ROW_W'(ROWS - 1)) begin
               row_in = '0;
               if (state_ff == ST_INIT) begin
                  state_in = ST_IDLE;
               end else begin
                  used_cnt_in = '0;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               pos_in     = req_position;
               addr_ok_in = (req_type_code == owner_type_ff) &&
                            (req_blob_tag == owner_blob_ff) &&
                            !req_position[POS_W-1] && (object_size_ff != '0);
               status_in  = STAT_OK;
               found_in   = '0;
               phase_in   = 1'b0;
               row_in     = '0;
               case (req_command)
                  CMD_FIND: begin
                     row_in = uc_row;
                     if (used_cnt_ff >= lim) begin
                        status_in = STAT_NO_SPACE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_TEST, CMD_USED, CMD_FREE: begin
                     state_in = ST_MUL;
                  end
                  CMD_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     status_in = STAT_INVALID;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (!addr_ok_ff) begin
               status_in = STAT_INVALID;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (pos_ff >= POS_W'(prod_ff)) begin
               status_in = STAT_INVALID;
               state_in  = ST_DONE;
            end else begin
               rem_in   = pos_ff[PROD_W-1:0];
               dvs_in   = PROD_W'(object_size_ff) << (CNT_W - 1);
               step_in  = STEP_W'(CNT_W);
               slot_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_ff >= dvs_ff) begin
               rem_in  = rem_ff - dvs_ff;
               slot_in = {slot_ff[CNT_W-2:0], 1'b1};
            end else begin
               slot_in = {slot_ff[CNT_W-2:0], 1'b0};
            end
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DCHK;
            end
         end
         ST_DCHK: begin
            if (rem_ff != '0) begin
               status_in = STAT_INVALID;
               state_in  = ST_DONE;
            end else begin
               row_in   = ROW_W'(slot_ff >> WORD_SEL);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_FIND: begin
                  if (any_free) begin
                     slot_in  = CNT_W'({row_ff, free_sel});
                     state_in = ST_FMUL;
                  end else if (!phase_ff) begin
                     if (row_ff == last_row) begin
                        if (used_cnt_ff == '0) begin
                           status_in = STAT_NO_SPACE;
                        end else begin
                           phase_in = 1'b1;
                           row_in   = '0;
                           state_in = ST_READ;
                        end
                     end else begin
                        row_in   = row_ff + ROW_W'(1);
                        state_in = ST_READ;
                     end
                  end else if (row_ff == uc_row) begin
                     status_in = STAT_NO_SPACE;
                  end else begin
                     row_in   = row_ff + ROW_W'(1);
                     state_in = ST_READ;
                  end
               end
               CMD_TEST: begin
                  if (used_cnt_ff >= lim) begin
                     status_in = STAT_NO_SPACE;
                  end else if (cur_bit) begin
                     status_in = STAT_NOT_FOUND;
                  end
               end
               CMD_USED: begin
                  if ((used_cnt_ff >= lim) || cur_bit) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     mem_we      = 1'b1;
                     mem_wdata   = rd_data_ff | (WORD_W'(1) << slot_ff[WORD_SEL-1:0]);
                     used_cnt_in = used_cnt_ff + CNT_W'(1);
                  end
               end
               default: begin
                  if ((used_cnt_ff == '0) || !cur_bit) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     mem_we      = 1'b1;
                     mem_wdata   = rd_data_ff & ~(WORD_W'(1) << slot_ff[WORD_SEL-1:0]);
                     used_cnt_in = used_cnt_ff - CNT_W'(1);
                  end
               end
            endcase
         end
         ST_FMUL: begin
            state_in = ST_FOUT;
         end
         ST_FOUT: begin
            found_in = prod_ff[FOUND_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_cnt_in    = used_cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[row_ff] <= mem_wdata;
      end
      rd_data_ff <= map_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         row_ff         <= '0;
         used_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         object_size_ff <= OSIZE_W'(1);
         slot_limit_ff  <= '0;
         owner_type_ff  <= '0;
         owner_blob_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         used_cnt_ff  <= used_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OBJECT_SIZE: object_size_ff <= csr_write_data[OSIZE_W-1:0];
               CSR_SLOT_LIMIT:  slot_limit_ff  <= csr_write_data[CNT_W-1:0];
               CSR_OWNER_TYPE:  owner_type_ff  <= csr_write_data[TYPE_W-1:0];
               CSR_OWNER_BLOB:  owner_blob_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      addr_ok_ff    <= addr_ok_in;
      slot_ff       <= slot_in;
      phase_ff      <= phase_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // The used count moves by one at most, or drops to zero on a clear.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (used_cnt_ff == $past(used_cnt_ff)) || (used_cnt_ff == $past(used_cnt_ff) + CNT_W'(1)) ||
      (used_cnt_ff == $past(used_cnt_ff) - CNT_W'(1)) || (used_cnt_ff == '0))
      else $error("used count jumped");

   // Only a successful find reports an offset.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_found_ff == '0))
      else $error("offset reported without a successful find");

   // A new result is loaded only from the completion step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result loaded outside completion");

   // The map is never written while a transaction is being accepted.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !mem_we)
      else $error("map write while idle");

endmodule

/* sim/sba_checker.sv */
// ----------------------------------------------------------------------------
// sba_checker
// Watches the request and response channels of the slot bitmap allocator,
// keeps its own copy of the used-bit map and registers, predicts each
// response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sba_checker
   import sba_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [POS_W-1:0]      req_position,
   input  logic [TYPE_W-1:0]     req_type_code,
   input  logic [BLOB_W-1:0]     req_blob_tag,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STAT_W-1:0]     rsp_status,
   input  logic [FOUND_W-1:0]    rsp_found_position,
   input  logic [CNT_W-1:0]      rsp_slots_used,
   output int                    fail_count,
   output int                    pending,
   output int                    responses_seen
);

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [FOUND_W-1:0] found;
      logic [CNT_W-1:0]   used;
   } alloc_result_type;

   logic [OSIZE_W-1:0] slot_bytes;
   logic [CNT_W-1:0]   lim_reg;
   logic [TYPE_W-1:0]  own_type;
   logic [BLOB_W-1:0]  own_blob;
   bit                 used_map [SLOTS];
   int unsigned        used_cnt;
   alloc_result_type   expected_results [$];

   function automatic longint unsigned active_limit();
      return (lim_reg < SLOTS) ? lim_reg : SLOTS;
   endfunction

   // Returns the slot index, or -1 when the address does not decode.
   function automatic longint decode_slot(logic [POS_W-1:0] pos,
                                          logic [TYPE_W-1:0] tc,
                                          logic [BLOB_W-1:0] bt);
      longint unsigned p;
      if (tc != own_type || bt != own_blob) return -1;
      if (pos[POS_W-1]) return -1;
      if (slot_bytes == 0) return -1;
      p = pos;
      if (p >= active_limit() * slot_bytes) return -1;
      if (p % slot_bytes != 0) return -1;
      return p / slot_bytes;
   endfunction

   function automatic alloc_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                      logic [POS_W-1:0] pos,
                                                      logic [TYPE_W-1:0] tc,
                                                      logic [BLOB_W-1:0] bt);
      alloc_result_type r;
      longint unsigned lim;
      longint s;
      longint unsigned i;
      bit hit;
      lim = active_limit();
      r = '0;
      r.status = STAT_OK;
      case (cmd)
         CMD_FIND: begin
            hit = 0;
            s = 0;
            if (used_cnt >= lim) r.status = STAT_NO_SPACE;
            else begin
               for (i = used_cnt; i < lim && !hit; i++)
                  if (!used_map[i]) begin s = i; hit = 1; end
               for (i = 0; i < used_cnt && i < lim && !hit; i++)
                  if (!used_map[i]) begin s = i; hit = 1; end
               if (!hit) r.status = STAT_NO_SPACE;
               else r.found = s * slot_bytes;
            end
         end
         CMD_TEST: begin
            s = decode_slot(pos, tc, bt);
            if (s < 0) r.status = STAT_INVALID;
            else if (used_cnt >= lim) r.status = STAT_NO_SPACE;
            else if (used_map[s]) r.status = STAT_NOT_FOUND;
         end
         CMD_USED: begin
            s = decode_slot(pos, tc, bt);
            if (s < 0) r.status = STAT_INVALID;
            else if (used_cnt >= lim || used_map[s]) r.status = STAT_NOT_FOUND;
            else begin
               used_map[s] = 1;
               used_cnt++;
            end
         end
         CMD_FREE: begin
            s = decode_slot(pos, tc, bt);
            if (s < 0) r.status = STAT_INVALID;
            else if (used_cnt == 0 || !used_map[s]) r.status = STAT_NOT_FOUND;
            else begin
               used_map[s] = 0;
               used_cnt--;
            end
         end
         CMD_CLEAR: begin
            foreach (used_map[k]) used_map[k] = 0;
            used_cnt = 0;
         end
         default: r.status = STAT_INVALID;
      endcase
      r.used = used_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (reset) begin
         slot_bytes = 1;
         lim_reg = 0;
         own_type = 0;
         own_blob = 0;
         foreach (used_map[k]) used_map[k] = 0;
         used_cnt = 0;
         expected_results.delete();
         fail_count = 0;
         responses_seen = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OBJECT_SIZE: slot_bytes = csr_write_data[OSIZE_W-1:0];
               CSR_SLOT_LIMIT:  lim_reg  = csr_write_data[CNT_W-1:0];
               CSR_OWNER_TYPE:  own_type = csr_write_data[TYPE_W-1:0];
               CSR_OWNER_BLOB:  own_blob = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_command(req_command, req_position,
                                                     req_type_code, req_blob_tag));
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response with nothing expected: status=%0d found=%0h used=%0d",
                           rsp_status, rsp_found_position, rsp_slots_used);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_status !== exp_r.status || rsp_found_position !== exp_r.found ||
                   rsp_slots_used !== exp_r.used) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch #%0d: expected status=%0d found=%0h used=%0d,",
                               " got status=%0d found=%0h used=%0d"},
                              responses_seen, exp_r.status, exp_r.found, exp_r.used,
                              rsp_status, rsp_found_position, rsp_slots_used);
               end
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives the slot bitmap allocator through several register settings with
// directed and random allocation traffic under varying back-pressure, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
   import sba_pkg::*;

   localparam int SLOTS       = SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 2500000;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command;
   logic signed [POS_W-1:0] req_position;
   logic [TYPE_W-1:0]     req_type_code;
   logic [BLOB_W-1:0]     req_blob_tag;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STAT_W-1:0]     rsp_status;
   logic [FOUND_W-1:0]    rsp_found_position;
   logic [CNT_W-1:0]      rsp_slots_used;
   int                    fail_count;
   int                    pending;
   int                    responses_seen;

   int  send_idle_pct;
   int  stall_pct;
   bit  hold_off;
   int  cycle_count;
   int  sent_count;

   // Current shape of the traffic, mirrored from the register writes.
   longint unsigned cur_size;
   int              cur_limit;
   logic [TYPE_W-1:0] cur_type;
   logic [BLOB_W-1:0] cur_blob;

   slot_bitmap_allocator_core #(.SLOTS(SLOTS)) dut (.*);

   sba_checker #(.SLOTS(SLOTS)) u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending);
         $display("** slot_bitmap_allocator_core: FAILED **");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold-off when asked.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_OBJECT_SIZE: cur_size = val[OSIZE_W-1:0];
         CSR_SLOT_LIMIT:  cur_limit = val[CNT_W-1:0];
         CSR_OWNER_TYPE:  cur_type = val[TYPE_W-1:0];
         default:         cur_blob = val;
      endcase
   endtask

   task automatic configure(longint unsigned osize, int lim,
                            logic [TYPE_W-1:0] tc, logic [BLOB_W-1:0] bt);
      write_csr(CSR_OBJECT_SIZE, osize);
      write_csr(CSR_SLOT_LIMIT, lim);
      write_csr(CSR_OWNER_TYPE, tc);
      write_csr(CSR_OWNER_BLOB, bt);
   endtask

   // Waits for every response, then lets any sweep in progress finish.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic send(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                       logic [TYPE_W-1:0] tc, logic [BLOB_W-1:0] bt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_position <= pos;
      req_type_code <= tc;
      req_blob_tag <= bt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Well-formed address for a slot under the current settings.
   task automatic send_slot(logic [CMD_W-1:0] cmd, int slot);
      send(cmd, slot * cur_size, cur_type, cur_blob);
   endtask

   task automatic random_item();
      int r;
      int span;
      logic [POS_W-1:0] pos;
      r = $urandom_range(99);
      span = (cur_limit == 0) ? 1 : cur_limit + 1;
      if (r < 80) begin
         r = $urandom_range(99);
         send_slot(r < 15 ? CMD_FIND : r < 35 ? CMD_TEST : r < 70 ? CMD_USED :
                   r < 98 ? CMD_FREE : CMD_CLEAR, $urandom_range(span - 1));
      end else begin
         pos = {$urandom, $urandom};
         r = $urandom_range(3);
         if (r == 0) pos = $urandom_range(span) * cur_size + $urandom_range(3);
         send($urandom_range(7), pos,
              $urandom_range(1) ? cur_type : TYPE_W'($urandom),
              $urandom_range(1) ? cur_blob : {$urandom, $urandom});
      end
   endtask

   initial begin
      cycle_count = 0;
      sent_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_command = '0;
      req_position = '0;
      req_type_code = '0;
      req_blob_tag = '0;
      cur_size = 1;
      cur_limit = 0;
      cur_type = 0;
      cur_blob = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero limit, so a find and a mark used are refused.
      send(CMD_FIND, 0, 0, 0);
      send(CMD_USED, 0, 0, 0);
      drain();

      // Directed: small map, every command and the edge addresses.
      configure(8, 4, 16'hffff, 64'hffff_ffff_ffff_ffff);
      send_slot(CMD_USED, 0);
      send_slot(CMD_USED, 0);
      send_slot(CMD_TEST, 0);
      send_slot(CMD_TEST, 1);
      send_slot(CMD_FIND, 0);
      send_slot(CMD_USED, 1);
      send_slot(CMD_USED, 2);
      send_slot(CMD_USED, 3);
      send_slot(CMD_FIND, 0);
      send_slot(CMD_TEST, 3);
      send_slot(CMD_FREE, 0);
      send_slot(CMD_FIND, 0);
      send(CMD_TEST, -1, cur_type, cur_blob);
      send(CMD_TEST, 32, cur_type, cur_blob);
      send(CMD_TEST, 9, cur_type, cur_blob);
      send(CMD_TEST, 8, 16'h0000, cur_blob);
      send(CMD_TEST, 8, cur_type, 64'h0);
      send(CMD_TEST, {1'b0, {40{1'b1}}}, cur_type, cur_blob);
      send(3'd5, 0, cur_type, cur_blob);
      send(3'd7, 0, cur_type, cur_blob);
      send_slot(CMD_CLEAR, 0);
      send_slot(CMD_FREE, 2);
      drain();

      // Lower the limit below the used count, then widen to the maximum.
      configure(1048576, 4096, 16'h1234, 64'h0123_4567_89ab_cdef);
      for (int i = 0; i < 6; i++) send_slot(CMD_USED, 4095 - i);
      send_slot(CMD_FIND, 0);
      drain();
      write_csr(CSR_SLOT_LIMIT, 2);
      send_slot(CMD_FIND, 0);
      drain();
      write_csr(CSR_SLOT_LIMIT, 8191);
      send_slot(CMD_FREE, 4095);
      send_slot(CMD_FIND, 0);
      drain();
      write_csr(CSR_OBJECT_SIZE, 0);
      send(CMD_USED, 0, cur_type, cur_blob);
      send_slot(CMD_FIND, 0);
      send_slot(CMD_CLEAR, 0);
      drain();

      // Random phases over several settings and idling patterns.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         case (ph)
            0: configure(1, 16, $urandom, {$urandom, $urandom});
            1: configure(1048576, 64, $urandom, {$urandom, $urandom});
            2: configure($urandom_range(1, 100), 32, $urandom, {$urandom, $urandom});
            3: configure(3, 1, 0, 0);
            4: configure(7, 8, 16'hffff, 64'hffff_ffff_ffff_ffff);
            5: configure(5, 64, $urandom, {$urandom, $urandom});
            6: configure($urandom_range(1, 2000), 128, $urandom, {$urandom, $urandom});
            default: configure(4096, 4096, $urandom, {$urandom, $urandom});
         endcase
         for (int n = 0; n < 190; n++) random_item();
         if (ph == 2) begin
            // Hold the response side off while requests keep coming.
            fork
               begin
                  hold_off = 1;
                  repeat (2000) @(posedge clock);
                  hold_off = 0;
               end
               for (int n = 0; n < 12; n++) random_item();
            join
         end
         drain();
      end

      $display("run covered %0d transactions and %0d responses over many register settings",
               sent_count, responses_seen);
      $display("with zero size, zero and clamped limits, wrapped searches and a long stall");
      if (fail_count == 0)
         $display("** slot_bitmap_allocator_core: PASSED **");
      else
         $display("** slot_bitmap_allocator_core: FAILED **");
      $finish;
   end

endmodule
